[rtl/id3hp_pkg.sv]
// ----------------------------------------------------------------------------
// ID3v2 header parser package
// Shared types, phase codes, result kinds, status codes and header constants.
// ----------------------------------------------------------------------------
package id3hp_pkg;

  localparam int SizeW = 28;
  localparam int SyncW = 7;

  localparam logic [7:0] MagicI    = 8'h49;
  localparam logic [7:0] MagicD    = 8'h44;
  localparam logic [7:0] Magic3    = 8'h33;
  localparam logic [7:0] BadVer    = 8'hFF;
  localparam logic [7:0] FlagsLow  = 8'h0F;
  localparam logic [7:0] SyncTop   = 8'h80;
  localparam int         ExtBit    = 6;
  localparam logic [7:0] LastSync  = 8'd3;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_MAGIC_D    = 4'd1;
  localparam logic [3:0] PH_MAGIC_3    = 4'd2;
  localparam logic [3:0] PH_VERSION    = 4'd3;
  localparam logic [3:0] PH_REVISION   = 4'd4;
  localparam logic [3:0] PH_FLAGS      = 4'd5;
  localparam logic [3:0] PH_SIZE       = 4'd6;
  localparam logic [3:0] PH_EXT_SIZE   = 4'd7;
  localparam logic [3:0] PH_COUNT      = 4'd8;
  localparam logic [3:0] PH_FLAG_BYTES = 4'd9;

  localparam logic [1:0] KIND_FLAG   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NO_TAG      = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_BAD_FLAGS   = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE    = 3'd4;
  localparam logic [2:0] ST_BAD_EXT     = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_stream;
  } item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0]       status;
    logic [7:0]       major_version;
    logic [7:0]       revision_number;
    logic [7:0]       header_flags;
    logic [SizeW-1:0] tag_size;
    logic [SizeW-1:0] ext_hdr_size;
    logic [7:0]       flag_byte_count;
    logic [7:0]       flag_byte_index;
    logic [7:0]       flag_byte_value;
  } res_t;

endpackage

[rtl/id3hp_ifs.sv]
// ----------------------------------------------------------------------------
// ID3v2 header parser channels
// Valid/ready channels for input bytes and parse results.
// ----------------------------------------------------------------------------
interface id3hp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_stream;

  modport source (output valid, output data_byte, output start_of_stream, input ready);
  modport sink   (input valid, input data_byte, input start_of_stream, output ready);
endinterface

interface id3hp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic [7:0]  major_version;
  logic [7:0]  revision_number;
  logic [7:0]  header_flags;
  logic [27:0] tag_size;
  logic [27:0] ext_hdr_size;
  logic [7:0]  flag_byte_count;
  logic [7:0]  flag_byte_index;
  logic [7:0]  flag_byte_value;

  modport source (output valid, output kind, output status, output major_version,
                  output revision_number, output header_flags, output tag_size,
                  output ext_hdr_size, output flag_byte_count,
                  output flag_byte_index, output flag_byte_value, input ready);
  modport sink   (input valid, input kind, input status, input major_version,
                  input revision_number, input header_flags, input tag_size,
                  input ext_hdr_size, input flag_byte_count,
                  input flag_byte_index, input flag_byte_value, output ready);
endinterface

[rtl/id3hp_in_stage.sv]
// ----------------------------------------------------------------------------
// ID3v2 header parser input stage
// Registers each incoming word and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module id3hp_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  id3hp_in_if.sink            in_ch,
  input  logic                advance,
  output logic                item_valid,
  output id3hp_pkg::item_t    item
);
  import id3hp_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ch.ready = !valid_r || advance;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte       <= in_ch.data_byte;
      item_r.start_of_stream <= in_ch.start_of_stream;
    end
  end

endmodule

[rtl/id3hp_parse.sv]
// ----------------------------------------------------------------------------
// ID3v2 header parser state machine
// Checks and decodes one header byte per step and forms its result, if any.
// ----------------------------------------------------------------------------
module id3hp_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  id3hp_pkg::item_t item,
  output logic             res_valid,
  output id3hp_pkg::res_t  res
);
  import id3hp_pkg::*;

  logic [3:0]       phase_r,    phase_nxt;
  logic [7:0]       pos_r,      pos_nxt;
  logic [7:0]       ver_r,      ver_nxt;
  logic [7:0]       rev_r,      rev_nxt;
  logic [7:0]       flags_r,    flags_nxt;
  logic [SizeW-1:0] size_r,     size_nxt;
  logic [SizeW-1:0] ext_r,      ext_nxt;
  logic [7:0]       count_r,    count_nxt;
  logic [7:0]       b;
  logic [SizeW-1:0] size_shift;
  logic [SizeW-1:0] ext_shift;
  logic [7:0]       pos_inc;
  res_t             base;

  assign b          = item.data_byte;
  assign size_shift = {size_r[SizeW-SyncW-1:0], b[SyncW-1:0]};
  assign ext_shift  = {ext_r[SizeW-SyncW-1:0], b[SyncW-1:0]};
  assign pos_inc    = pos_r + 8'd1;

  always_comb begin
    base                 = '0;
    base.kind            = KIND_ACCEPT;
    base.status          = ST_OK;
    base.major_version   = ver_r;
    base.revision_number = rev_r;
    base.header_flags    = flags_r;
    base.tag_size        = size_r;
    base.ext_hdr_size    = flags_r[ExtBit] ? ext_r : '0;
    base.flag_byte_count = flags_r[ExtBit] ? count_r : '0;
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    ver_nxt   = ver_r;
    rev_nxt   = rev_r;
    flags_nxt = flags_r;
    size_nxt  = size_r;
    ext_nxt   = ext_r;
    count_nxt = count_r;
    res_valid = 1'b0;
    res       = '0;
    res.kind  = KIND_REJECT;

    if (item.start_of_stream) begin
      phase_nxt = PH_MAGIC_D;
      pos_nxt   = '0;
      ver_nxt   = '0;
      rev_nxt   = '0;
      flags_nxt = '0;
      size_nxt  = '0;
      ext_nxt   = '0;
      count_nxt = '0;
      if (b != MagicI) begin
        res_valid  = 1'b1;
        res.status = ST_NO_TAG;
        phase_nxt  = PH_IDLE;
      end
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_MAGIC_D: begin
          if (b != MagicD) begin
            res_valid  = 1'b1;
            res.status = ST_NO_TAG;
            phase_nxt  = PH_IDLE;
          end else begin
            phase_nxt = PH_MAGIC_3;
          end
        end
        PH_MAGIC_3: begin
          if (b != Magic3) begin
            res_valid  = 1'b1;
            res.status = ST_NO_TAG;
            phase_nxt  = PH_IDLE;
          end else begin
            phase_nxt = PH_VERSION;
          end
        end
        PH_VERSION: begin
          if (b == BadVer) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_VERSION;
            phase_nxt  = PH_IDLE;
          end else begin
            ver_nxt   = b;
            phase_nxt = PH_REVISION;
          end
        end
        PH_REVISION: begin
          if (b == BadVer) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_VERSION;
            phase_nxt  = PH_IDLE;
          end else begin
            rev_nxt   = b;
            phase_nxt = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          if ((b & FlagsLow) != 8'd0) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_FLAGS;
            phase_nxt  = PH_IDLE;
          end else begin
            flags_nxt = b;
            pos_nxt   = '0;
            size_nxt  = '0;
            phase_nxt = PH_SIZE;
          end
        end
        PH_SIZE: begin
          if ((b & SyncTop) != 8'd0) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_SIZE;
            phase_nxt  = PH_IDLE;
          end else begin
            size_nxt = size_shift;
            pos_nxt  = pos_inc;
            if (pos_r == LastSync) begin
              pos_nxt = '0;
              if (!flags_r[ExtBit]) begin
                res_valid    = 1'b1;
                res          = base;
                res.tag_size = size_shift;
                phase_nxt    = PH_IDLE;
              end else begin
                ext_nxt   = '0;
                phase_nxt = PH_EXT_SIZE;
              end
            end
          end
        end
        PH_EXT_SIZE: begin
          if ((b & SyncTop) != 8'd0) begin
            res_valid  = 1'b1;
            res.status = ST_BAD_EXT;
            phase_nxt  = PH_IDLE;
          end else begin
            ext_nxt = ext_shift;
            pos_nxt = pos_inc;
            if (pos_r == LastSync) begin
              pos_nxt   = '0;
              phase_nxt = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          count_nxt           = b;
          pos_nxt             = '0;
          phase_nxt           = (b == 8'd0) ? PH_IDLE : PH_FLAG_BYTES;
          res_valid           = 1'b1;
          res                 = base;
          res.flag_byte_count = b;
        end
        PH_FLAG_BYTES: begin
          pos_nxt = pos_inc;
          if (pos_inc >= count_r) begin
            phase_nxt = PH_IDLE;
          end
          res_valid           = 1'b1;
          res                 = base;
          res.kind            = KIND_FLAG;
          res.flag_byte_index = pos_r;
          res.flag_byte_value = b;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pos_r   <= '0;
      ver_r   <= '0;
      rev_r   <= '0;
      flags_r <= '0;
      size_r  <= '0;
      ext_r   <= '0;
      count_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      ver_r   <= ver_nxt;
      rev_r   <= rev_nxt;
      flags_r <= flags_nxt;
      size_r  <= size_nxt;
      ext_r   <= ext_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/id3hp_out_stage.sv]
// ----------------------------------------------------------------------------
// ID3v2 header parser result register
// Holds one result word on the output channel until it is taken.
// ----------------------------------------------------------------------------
module id3hp_out_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  logic            res_valid,
  input  id3hp_pkg::res_t res,
  output logic            free,
  id3hp_out_if.source     out_ch
);
  import id3hp_pkg::*;

  logic valid_r;
  res_t res_r;

  assign free         = !valid_r || out_ch.ready;
  assign out_ch.valid = valid_r;

  assign out_ch.kind            = res_r.kind;
  assign out_ch.status          = res_r.status;
  assign out_ch.major_version   = res_r.major_version;
  assign out_ch.revision_number = res_r.revision_number;
  assign out_ch.header_flags    = res_r.header_flags;
  assign out_ch.tag_size        = res_r.tag_size;
  assign out_ch.ext_hdr_size    = res_r.ext_hdr_size;
  assign out_ch.flag_byte_count = res_r.flag_byte_count;
  assign out_ch.flag_byte_index = res_r.flag_byte_index;
  assign out_ch.flag_byte_value = res_r.flag_byte_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= res_valid;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule

[rtl/id3v2_header_parser.sv]
// ----------------------------------------------------------------------------
// ID3v2 tag header parser
// Takes one stream byte per clock while results drain and reports the decoded
// header, each extended flag byte, or a rejection with its status code.
// ----------------------------------------------------------------------------
// The parser takes one byte every clock while results are being taken. A
// byte is held in the input register, checked and decoded by the header
// state machine, and its result, if any, is written to the output register
// when the state machine advances on that byte. A stalled result register
// holds the state machine and, once the input register is also full, drops
// in_ch.ready. A byte with start_of_stream set always restarts the header.
module id3v2_header_parser (
  input  logic         clk,
  input  logic         rst_n,
  id3hp_in_if.sink     in_ch,
  id3hp_out_if.source  out_ch
);
  import id3hp_pkg::*;

  logic  item_valid;
  item_t item;
  logic  res_valid;
  res_t  res;
  logic  out_free;
  logic  advance;

  assign advance = item_valid && out_free;

  id3hp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  id3hp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  id3hp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_ch    (out_ch)
  );

endmodule

[rtl/id3hp_checker.sv]
// ----------------------------------------------------------------------------
// ID3v2 header parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module id3hp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [2:0]  status,
  input logic [7:0]  major_version,
  input logic [27:0] tag_size,
  input logic [7:0]  flag_byte_count,
  input logic [7:0]  flag_byte_index
);
  import id3hp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result word dropped before it was taken.");

  a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("Result word shown right after reset.");

  a_reject_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_REJECT |->
      status != ST_OK && major_version == 8'd0 && tag_size == '0)
    else $error("Rejection carries header fields or an ok status.");

  a_good_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind != KIND_REJECT |-> status == ST_OK)
    else $error("Accepted or flag word carries an error status.");

  a_flag_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_FLAG |-> flag_byte_index < flag_byte_count)
    else $error("Extended flag byte index beyond the announced count.");

endmodule

bind id3v2_header_parser id3hp_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .kind            (out_ch.kind),
  .status          (out_ch.status),
  .major_version   (out_ch.major_version),
  .tag_size        (out_ch.tag_size),
  .flag_byte_count (out_ch.flag_byte_count),
  .flag_byte_index (out_ch.flag_byte_index)
);

[tb/id3v2_header_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ID3v2 tag header parser testbench
// Feeds the parser a directed byte table and then a long run of random tag
// headers, some of them corrupted, cut short or mixed with stray bytes. Each
// result word is checked field by field against a predictor of the header
// state machine or a typed result. The sender idles in bursts and the receiver
// stalls in changing patterns, with one long hold-off so the parser backs up.
// ----------------------------------------------------------------------------
module id3v2_header_parser_tb;
  import id3hp_pkg::*;

  localparam int unsigned DIR_ROWS = 27;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_AFTER = 100;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_REJECT} row_check_t;
  typedef enum {RX_ALWAYS, RX_MOSTLY, RX_ALTERNATE, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       sos;
    row_check_t how;
    logic [2:0] st;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       sos;
    bit         typed;
    bit         typed_has;
    res_t       typed_res;
  } stim_t;

  typedef struct packed {
    logic [3:0]       phase;
    logic [7:0]       pos;
    logic [7:0]       ver;
    logic [7:0]       rev;
    logic [7:0]       flags;
    logic [SizeW-1:0] tsize;
    logic [SizeW-1:0] esize;
    logic [7:0]       nflags;
  } parse_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  id3hp_in_if  in_ch ();
  id3hp_out_if out_ch ();

  id3v2_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  parse_state_t hdr_state = '0;
  res_t         pending_results[$];
  stim_t        byte_stream[$];
  dir_row_t     directed_rows [DIR_ROWS];
  int unsigned  mismatches = 0;
  bit           sending_done = 1'b0;

  always #10 clk = ~clk;

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic res_t header_word(input logic [1:0] k, input logic [7:0] idx,
                                       input logic [7:0] val);
    res_t r;
    r = '0;
    r.kind = k;
    r.status = ST_OK;
    r.major_version = hdr_state.ver;
    r.revision_number = hdr_state.rev;
    r.header_flags = hdr_state.flags;
    r.tag_size = hdr_state.tsize;
    if (hdr_state.flags[ExtBit]) begin
      r.ext_hdr_size = hdr_state.esize;
      r.flag_byte_count = hdr_state.nflags;
    end
    r.flag_byte_index = idx;
    r.flag_byte_value = val;
    return r;
  endfunction

  function automatic bit parse_header_byte(input logic [7:0] b, input logic sos,
                                           output res_t r);
    logic [2:0] fail;
    bit has;
    fail = ST_OK;
    has = 1'b0;
    r = '0;
    if (sos) begin
      hdr_state = '0;
      hdr_state.phase = PH_MAGIC_D;
      if (b != MagicI) fail = ST_NO_TAG;
    end else begin
      case (hdr_state.phase)
        PH_MAGIC_D: begin
          if (b != MagicD) fail = ST_NO_TAG;
          else hdr_state.phase = PH_MAGIC_3;
        end
        PH_MAGIC_3: begin
          if (b != Magic3) fail = ST_NO_TAG;
          else hdr_state.phase = PH_VERSION;
        end
        PH_VERSION: begin
          if (b == BadVer) begin
            fail = ST_BAD_VERSION;
          end else begin
            hdr_state.ver = b;
            hdr_state.phase = PH_REVISION;
          end
        end
        PH_REVISION: begin
          if (b == BadVer) begin
            fail = ST_BAD_VERSION;
          end else begin
            hdr_state.rev = b;
            hdr_state.phase = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          if ((b & FlagsLow) != 8'h00) begin
            fail = ST_BAD_FLAGS;
          end else begin
            hdr_state.flags = b;
            hdr_state.pos = '0;
            hdr_state.tsize = '0;
            hdr_state.phase = PH_SIZE;
          end
        end
        PH_SIZE: begin
          if ((b & SyncTop) != 8'h00) begin
            fail = ST_BAD_SIZE;
          end else begin
            hdr_state.tsize = {hdr_state.tsize[SizeW-SyncW-1:0], b[SyncW-1:0]};
            if (hdr_state.pos != LastSync) begin
              hdr_state.pos = hdr_state.pos + 1'b1;
            end else begin
              hdr_state.pos = '0;
              if (!hdr_state.flags[ExtBit]) begin
                hdr_state.phase = PH_IDLE;
                r = header_word(KIND_ACCEPT, '0, '0);
                has = 1'b1;
              end else begin
                hdr_state.esize = '0;
                hdr_state.phase = PH_EXT_SIZE;
              end
            end
          end
        end
        PH_EXT_SIZE: begin
          if ((b & SyncTop) != 8'h00) begin
            fail = ST_BAD_EXT;
          end else begin
            hdr_state.esize = {hdr_state.esize[SizeW-SyncW-1:0], b[SyncW-1:0]};
            if (hdr_state.pos != LastSync) begin
              hdr_state.pos = hdr_state.pos + 1'b1;
            end else begin
              hdr_state.pos = '0;
              hdr_state.phase = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          hdr_state.nflags = b;
          hdr_state.pos = '0;
          hdr_state.phase = (b == 8'h00) ? PH_IDLE : PH_FLAG_BYTES;
          r = header_word(KIND_ACCEPT, '0, '0);
          has = 1'b1;
        end
        PH_FLAG_BYTES: begin
          r = header_word(KIND_FLAG, hdr_state.pos, b);
          has = 1'b1;
          hdr_state.pos = hdr_state.pos + 1'b1;
          if (hdr_state.pos >= hdr_state.nflags) hdr_state.phase = PH_IDLE;
        end
        default: hdr_state.phase = PH_IDLE;
      endcase
    end
    if (fail != ST_OK) begin
      r = '0;
      r.kind = KIND_REJECT;
      r.status = fail;
      hdr_state.phase = PH_IDLE;
      has = 1'b1;
    end
    return has;
  endfunction

  function automatic logic [7:0] sync_digit();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h7F;
      default: return 8'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin : sender
    stim_t       item;
    stim_t       cur;
    res_t        r;
    bit          has;
    bit          ext;
    bit          busy;
    logic [8:0]  hdr[$];
    logic [8:0]  w;
    logic [7:0]  v;
    logic [7:0]  flg;
    logic [7:0]  cnt;
    int unsigned next_idx;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned counted;
    int unsigned p;

    in_ch.valid <= 1'b0;
    in_ch.data_byte <= 8'h00;
    in_ch.start_of_stream <= 1'b0;

    directed_rows = '{
      '{8'h00,  1'b0, CHK_NONE,    ST_OK},
      '{8'hFF,  1'b1, CHK_REJECT,  ST_NO_TAG},
      '{MagicI, 1'b1, CHK_PREDICT, ST_OK},
      '{MagicD, 1'b0, CHK_PREDICT, ST_OK},
      '{Magic3, 1'b0, CHK_PREDICT, ST_OK},
      '{8'hFE,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h00,  1'b0, CHK_PREDICT, ST_OK},
      '{8'hF0,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h7F,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h7F,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h7F,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h7F,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h00,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h00,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h00,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h00,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h01,  1'b0, CHK_PREDICT, ST_OK},
      '{8'hFF,  1'b0, CHK_PREDICT, ST_OK},
      '{MagicI, 1'b1, CHK_PREDICT, ST_OK},
      '{MagicD, 1'b0, CHK_PREDICT, ST_OK},
      '{Magic3, 1'b0, CHK_PREDICT, ST_OK},
      '{MagicI, 1'b1, CHK_PREDICT, ST_OK},
      '{MagicD, 1'b0, CHK_PREDICT, ST_OK},
      '{Magic3, 1'b0, CHK_PREDICT, ST_OK},
      '{8'h00,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h00,  1'b0, CHK_PREDICT, ST_OK},
      '{8'h0F,  1'b0, CHK_REJECT,  ST_BAD_FLAGS}
    };

    foreach (directed_rows[i]) begin
      item = '0;
      item.data_byte = directed_rows[i].b;
      item.sos = directed_rows[i].sos;
      item.typed = (directed_rows[i].how != CHK_PREDICT);
      item.typed_has = (directed_rows[i].how == CHK_REJECT);
      if (item.typed_has) begin
        item.typed_res.kind = KIND_REJECT;
        item.typed_res.status = directed_rows[i].st;
      end
      byte_stream.push_back(item);
    end

    // Mostly well-formed headers; a quarter are broken at one byte or cut
    // short, and stray bytes now and then fall between headers.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      hdr.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          item = '0;
          item.data_byte = 8'($urandom_range(0, 255));
          byte_stream.push_back(item);
        end
      end
      flg = {4'($urandom_range(0, 15)), 4'h0};
      ext = flg[ExtBit];
      hdr.push_back({1'b1, MagicI});
      hdr.push_back({1'b0, MagicD});
      hdr.push_back({1'b0, Magic3});
      v = 8'($urandom_range(0, 254));
      hdr.push_back({1'b0, v});
      v = 8'($urandom_range(0, 254));
      hdr.push_back({1'b0, v});
      hdr.push_back({1'b0, flg});
      repeat (4) begin
        v = sync_digit();
        hdr.push_back({1'b0, v});
      end
      if (ext) begin
        repeat (4) begin
          v = sync_digit();
          hdr.push_back({1'b0, v});
        end
        case ($urandom_range(0, 39))
          0: cnt = 8'hFF;
          1, 2, 3: cnt = 8'($urandom_range(7, 40));
          default: cnt = 8'($urandom_range(0, 6));
        endcase
        hdr.push_back({1'b0, cnt});
        repeat (cnt) begin
          v = 8'($urandom_range(0, 255));
          hdr.push_back({1'b0, v});
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        p = hdr.size() - 1;
        case ($urandom_range(0, 5))
          0: begin
            p = $urandom_range(0, 2);
            w = hdr[p];
            v = 8'($urandom_range(1, 255));
            w[7:0] = w[7:0] ^ v;
            hdr[p] = w;
          end
          1: begin
            p = $urandom_range(3, 4);
            w = hdr[p];
            w[7:0] = BadVer;
            hdr[p] = w;
          end
          2: begin
            p = 5;
            w = hdr[p];
            w[3:0] = 4'($urandom_range(1, 15));
            hdr[p] = w;
          end
          3: begin
            p = $urandom_range(6, 9);
            w = hdr[p];
            w[7] = 1'b1;
            hdr[p] = w;
          end
          4: begin
            if (ext) begin
              p = $urandom_range(10, 13);
              w = hdr[p];
              w[7] = 1'b1;
              hdr[p] = w;
            end
          end
          default: p = $urandom_range(0, hdr.size() - 1);
        endcase
        while (hdr.size() > p + 1) void'(hdr.pop_back());
      end
      foreach (hdr[j]) begin
        item = '0;
        item.sos = hdr[j][8];
        item.data_byte = hdr[j][7:0];
        byte_stream.push_back(item);
      end
      counted += hdr.size();
    end

    next_idx = 0;
    burst_left = $urandom_range(1, 40);
    gap_left = 0;
    busy = 1'b1;
    do @(posedge clk); while (!rst_n);

    while (busy) begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) begin
        has = parse_header_byte(cur.data_byte, cur.sos, r);
        if (cur.typed) begin
          has = cur.typed_has;
          r = cur.typed_res;
        end
        if (has) pending_results.push_back(r);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (next_idx == byte_stream.size()) begin
          in_ch.valid <= 1'b0;
          busy = 1'b0;
        end else if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left--;
        end else begin
          cur = byte_stream[next_idx];
          next_idx++;
          in_ch.valid <= 1'b1;
          in_ch.data_byte <= cur.data_byte;
          in_ch.start_of_stream <= cur.sos;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap_left = $urandom_range(1, 6);
          end
        end
      end
    end
    sending_done = 1'b1;
  end

  initial begin : receiver
    rx_mode_t    mode;
    int unsigned left;
    int unsigned hold;
    int unsigned taken;
    bit          long_done;
    bit          alt;

    mode = RX_ALWAYS;
    left = 0;
    hold = 0;
    taken = 0;
    long_done = 1'b0;
    alt = 1'b0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) taken++;
      if (!long_done && taken >= HOLD_AFTER) begin
        long_done = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 200);
        end
        left--;
        alt = ~alt;
        case (mode)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
          RX_ALTERNATE: out_ch.ready <= alt;
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [SizeW-1:0] want,
                             input logic [SizeW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word arrived with none expected (kind %0d)", out_ch.kind);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", SizeW'(want.kind), SizeW'(out_ch.kind));
        check_field("status", SizeW'(want.status), SizeW'(out_ch.status));
        check_field("major_version", SizeW'(want.major_version),
                    SizeW'(out_ch.major_version));
        check_field("revision_number", SizeW'(want.revision_number),
                    SizeW'(out_ch.revision_number));
        check_field("header_flags", SizeW'(want.header_flags),
                    SizeW'(out_ch.header_flags));
        check_field("tag_size", want.tag_size, out_ch.tag_size);
        check_field("ext_hdr_size", want.ext_hdr_size, out_ch.ext_hdr_size);
        check_field("flag_byte_count", SizeW'(want.flag_byte_count),
                    SizeW'(out_ch.flag_byte_count));
        check_field("flag_byte_index", SizeW'(want.flag_byte_index),
                    SizeW'(out_ch.flag_byte_index));
        check_field("flag_byte_value", SizeW'(want.flag_byte_value),
                    SizeW'(out_ch.flag_byte_value));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : finish_run
    wait (sending_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
